// ===== rtl/core/ptvp_pkg.sv =====
// Package for the page table victim placement block: outcome codes and
// field widths. No dependencies.
package ptvp_pkg;

    localparam int PAGE_W = 51;
    localparam int TICK_W = 48;

    typedef enum logic [2:0] {
        OUT_HIT     = 3'd0,
        OUT_EMPTY   = 3'd1,
        OUT_SWAP    = 3'd2,
        OUT_FREE    = 3'd3,
        OUT_OLDEST  = 3'd4
    } outcome_t;

endpackage

// ===== rtl/core/page_table_victim_placement.sv =====
// Page table victim placement: direct-mapped frame table, victim buffer and
// backing directory, all in synchronous memories. Depends on ptvp_pkg.
//
// Usage:
//   s_axis: one word per page access, tdata = {current_tick, page_number},
//   page_number in the low 51 bits. m_axis: one result word per access.
//   Flow per access: a sequencer reads the set entry; on a miss to an occupied
//   set it walks the victim slots one by one; on an oldest-slot eviction it
//   walks the backing directory entry by entry up to its fill count, and it
//   walks it again for the fill on every miss but a swap.
//   One access is handled at a time. A finished result waits in the output
//   register while the next word is taken; that access then holds in its
//   last state, so a stalled receiver blocks the input one access later.
//   Reset: the set table has one valid bit per set, cleared by a sweep over
//   all TABLE_SETS sets after reset during which no word is taken. Victim
//   slots have valid bits in flip-flops; the directory uses a fill count.
module page_table_victim_placement #(
    parameter int TABLE_SETS    = 1024,
    parameter int VICTIM_SLOTS  = 8,
    parameter int BACKING_SLOTS = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [50:0] page_number, [98:51] current_tick, zero fill to 104 bits
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [2:0] outcome, [12:3] set_index, [15:13] victim_slot, [16] evict_write,
    // [67:17] evicted_page, [79:68] evict_slot, [80] fill_from_backing,
    // [92:81] fill_slot, [93] backing_full, zero fill to 96 bits
    output logic [95:0]   m_axis_tdata
);
    import ptvp_pkg::*;

    localparam int SW  = $clog2(TABLE_SETS);
    localparam int TW  = PAGE_W - SW;
    localparam int VW  = (VICTIM_SLOTS > 1) ? $clog2(VICTIM_SLOTS) : 1;
    localparam int VCW = $clog2(VICTIM_SLOTS + 1);
    localparam int BW  = $clog2(BACKING_SLOTS);
    localparam int BCW = $clog2(BACKING_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SET_RD, ST_SET_CHK, ST_VSCAN, ST_VDECIDE,
        ST_DIR_RD, ST_DIR_CHK, ST_FILL_RD, ST_FILL_CHK, ST_OUT
    } state_t;

    // memories
    logic [TW:0]       set_mem [TABLE_SETS];
    logic [PAGE_W-1:0] vic_page_mem [VICTIM_SLOTS];
    logic [TICK_W-1:0] vic_time_mem [VICTIM_SLOTS];
    logic [PAGE_W-1:0] dir_mem [BACKING_SLOTS];

    logic [TW:0]       set_rd;
    logic [PAGE_W-1:0] vp_rd;
    logic [TICK_W-1:0] vt_rd;
    logic [PAGE_W-1:0] dir_rd;

    state_t            state_reg;
    logic [SW-1:0]     clr_reg;
    logic [VICTIM_SLOTS-1:0] vvalid_reg;
    logic [VCW-1:0]    vuse_reg;
    logic [BCW-1:0]    bcount_reg;
    logic [PAGE_W-1:0] page_reg, old_page_reg, gone_reg;
    logic [TICK_W-1:0] tick_reg, best_t_reg;
    logic [VW-1:0]     vidx_reg, best_reg, slot_reg;
    logic              found_reg;
    logic [BCW-1:0]    didx_reg;
    logic              dfound_reg;
    logic              out_v_reg;
    logic [95:0]       out_reg;
    // result fields
    outcome_t          oc_reg;
    logic              ew_reg, ff_reg, bf_reg;
    logic [PAGE_W-1:0] ep_reg;
    logic [BW-1:0]     es_reg, fs_reg;
    logic              vwr_reg;

    logic [SW-1:0]     set_idx;
    logic [TW-1:0]     tag;
    logic [PAGE_W-1:0] page_in;
    logic [VW-1:0]     vrd_addr;
    logic [BW-1:0]     drd_addr;

    assign page_in = s_axis_tdata[PAGE_W-1:0];
    assign set_idx = page_reg[SW-1:0];
    assign tag     = page_reg[PAGE_W-1:SW];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;
    assign vrd_addr = vidx_reg;
    assign drd_addr = didx_reg[BW-1:0];

    // set table: clear sweep writes invalid, updates write valid tag
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            set_mem[clr_reg] <= '0;
        end else if (state_reg == ST_SET_CHK &&
                     !(set_rd[TW] && set_rd[TW-1:0] == tag)) begin
            set_mem[set_idx] <= {1'b1, tag};
        end
        set_rd <= set_mem[set_idx];
    end

    // victim buffer
    always_ff @(posedge aclk) begin
        if (vwr_reg) begin
            vic_page_mem[slot_reg] <= old_page_reg;
            vic_time_mem[slot_reg] <= tick_reg;
        end
        vp_rd <= vic_page_mem[vrd_addr];
        vt_rd <= vic_time_mem[vrd_addr];
    end

    // backing directory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIR_CHK && !dfound_reg && didx_reg == bcount_reg &&
            bcount_reg < BCW'(BACKING_SLOTS)) begin
            dir_mem[bcount_reg[BW-1:0]] <= gone_reg;
        end
        dir_rd <= dir_mem[drd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            vvalid_reg <= '0;
            vuse_reg   <= '0;
            bcount_reg <= '0;
            out_v_reg  <= 1'b0;
            vwr_reg    <= 1'b0;
        end else begin
            if (out_v_reg && m_axis_tready && state_reg != ST_OUT) out_v_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == SW'(TABLE_SETS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        page_reg  <= page_in;
                        tick_reg  <= s_axis_tdata[PAGE_W+TICK_W-1:PAGE_W];
                        state_reg <= ST_SET_RD;
                    end
                end
                ST_SET_RD: state_reg <= ST_SET_CHK;
                ST_SET_CHK: begin
                    ew_reg <= 1'b0; ep_reg <= '0; es_reg <= '0;
                    ff_reg <= 1'b0; fs_reg <= '0; bf_reg <= 1'b0;
                    slot_reg <= '0; didx_reg <= '0; dfound_reg <= 1'b0;
                    old_page_reg <= {set_rd[TW-1:0], set_idx};
                    if (set_rd[TW] && set_rd[TW-1:0] == tag) begin
                        oc_reg <= OUT_HIT;
                        state_reg <= ST_OUT;
                    end else if (!set_rd[TW]) begin
                        oc_reg <= OUT_EMPTY;
                        state_reg <= ST_FILL_RD;
                    end else begin
                        vidx_reg <= '0;
                        found_reg <= 1'b0;
                        best_reg <= '0;
                        state_reg <= ST_VSCAN;
                    end
                end
                // a read state and a decide state per slot; data of vidx_reg arrives next cycle
                ST_VSCAN: state_reg <= ST_VDECIDE;
                ST_VDECIDE: begin
                    if (!found_reg && vvalid_reg[vidx_reg] && vp_rd == page_reg) begin
                        found_reg <= 1'b1;
                        slot_reg  <= vidx_reg;
                    end
                    if (vidx_reg == '0 || vt_rd < best_t_reg) begin
                        best_t_reg <= vt_rd;
                        best_reg   <= vidx_reg;
                    end
                    if (vidx_reg != VW'(VICTIM_SLOTS - 1)) begin
                        vidx_reg  <= vidx_reg + VW'(1);
                        state_reg <= ST_VSCAN;
                    end else if (found_reg ||
                                 (vvalid_reg[vidx_reg] && vp_rd == page_reg)) begin
                        oc_reg <= OUT_SWAP;
                        vwr_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if (vuse_reg < VCW'(VICTIM_SLOTS)) begin
                        slot_reg <= vuse_reg[VW-1:0];
                        vvalid_reg[vuse_reg[VW-1:0]] <= 1'b1;
                        vuse_reg <= vuse_reg + VCW'(1);
                        oc_reg <= OUT_FREE;
                        vwr_reg <= 1'b1;
                        state_reg <= ST_FILL_RD;
                    end else begin
                        // final compare folded in: pick best, fetch its page
                        if (vt_rd < best_t_reg) slot_reg <= vidx_reg;
                        else slot_reg <= best_reg;
                        vidx_reg <= (vt_rd < best_t_reg) ? vidx_reg : best_reg;
                        oc_reg <= OUT_OLDEST;
                        state_reg <= ST_DIR_RD;
                        found_reg <= 1'b0;
                    end
                end
                ST_DIR_RD: begin
                    // first pass: latch evicted page once read returns
                    if (!found_reg) begin
                        found_reg <= 1'b1;
                    end else begin
                        if (didx_reg == '0) gone_reg <= vp_rd;
                        state_reg <= ST_DIR_CHK;
                    end
                end
                ST_DIR_CHK: begin
                    if (didx_reg < bcount_reg) begin
                        if (dir_rd == gone_reg) begin
                            ew_reg <= 1'b1; ep_reg <= gone_reg;
                            es_reg <= didx_reg[BW-1:0];
                            vwr_reg <= 1'b1; didx_reg <= '0;
                            state_reg <= ST_FILL_RD;
                        end else begin
                            didx_reg <= didx_reg + BCW'(1);
                            state_reg <= ST_DIR_RD;
                        end
                    end else begin
                        if (bcount_reg < BCW'(BACKING_SLOTS)) begin
                            ew_reg <= 1'b1; ep_reg <= gone_reg;
                            es_reg <= bcount_reg[BW-1:0];
                            bcount_reg <= bcount_reg + BCW'(1);
                        end else begin
                            bf_reg <= 1'b1;
                        end
                        vwr_reg <= 1'b1; didx_reg <= '0;
                        state_reg <= ST_FILL_RD;
                    end
                end
                ST_FILL_RD: begin
                    vwr_reg <= 1'b0;
                    state_reg <= ST_FILL_CHK;
                end
                ST_FILL_CHK: begin
                    if (didx_reg < bcount_reg) begin
                        if (dir_rd == page_reg) begin
                            ff_reg <= 1'b1; fs_reg <= didx_reg[BW-1:0];
                            state_reg <= ST_OUT;
                        end else begin
                            didx_reg <= didx_reg + BCW'(1);
                            state_reg <= ST_FILL_RD;
                        end
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    vwr_reg <= 1'b0;
                    if (!out_v_reg || m_axis_tready) begin
                        out_v_reg <= 1'b1;
                        out_reg <= {2'b0, bf_reg, 12'(fs_reg), ff_reg, 12'(es_reg),
                                    ep_reg, ew_reg, 3'(slot_reg), 10'(set_idx),
                                    3'(oc_reg)};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for page_table_victim_placement: directed table plus
// random page accesses, checked against an in-bench placement predictor.
// Depends on ptvp_pkg and the block's RTL.
module testbench;
    import ptvp_pkg::*;

    localparam int  SETS      = 1024;
    localparam int  VSLOTS    = 8;
    localparam int  DSLOTS    = 4096;
    localparam int  RAND_WORDS = 1880;
    localparam int  POOL_SIZE = 64;
    localparam int  LONG_HOLD = 3000;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam logic [50:0] PAGE_MAX = '1;
    localparam logic [47:0] TICK_MAX = '1;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;

    page_table_victim_placement u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // predictor copy of the block's state
    bit          tbl_valid [SETS];
    logic [40:0] tbl_tag   [SETS];
    bit          vb_valid  [VSLOTS];
    logic [50:0] vb_page   [VSLOTS];
    logic [47:0] vb_tick   [VSLOTS];
    int          vb_used;
    logic [50:0] dir_page  [DSLOTS];
    int          dir_count;

    logic [95:0] pending_results [$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    int          outcome_seen [5];
    int          words_sent = 0;

    // traffic shaping, percent of cycles
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int          hold_left = 0;

    typedef struct {
        logic [50:0] page;
        logic [47:0] tick;
        bit          fixed;
        logic [95:0] want;
    } access_row_t;

    access_row_t  directed [$];
    logic [50:0]  page_pool [POOL_SIZE];

    function automatic logic [95:0] pack_result(outcome_t oc, logic [9:0] set,
            logic [2:0] vslot, logic ew, logic [50:0] epage, logic [11:0] eslot,
            logic fb, logic [11:0] fslot, logic full);
        return {2'b00, full, fslot, fb, eslot, epage, ew, vslot, set, oc};
    endfunction

    function automatic int directory_lookup(logic [50:0] page);
        for (int i = 0; i < dir_count; i++)
            if (dir_page[i] == page) return i;
        return -1;
    endfunction

    // placement of one access: updates the predictor state, returns the word
    function automatic logic [95:0] place_page(logic [50:0] page, logic [47:0] tick);
        logic [9:0]  set;
        logic [40:0] tag;
        logic [50:0] old_page, gone;
        outcome_t    oc;
        int          slot, best, d, f;
        logic [2:0]  vslot;
        logic        ew, fb, full;
        logic [50:0] epage;
        logic [11:0] eslot, fslot;
        bit          do_fill;
        set = page[9:0];
        tag = page[50:10];
        vslot = '0; ew = 0; epage = '0; eslot = '0; fb = 0; fslot = '0; full = 0;
        if (tbl_valid[set] && tbl_tag[set] == tag) begin
            oc = OUT_HIT;
        end else begin
            do_fill = 1;
            if (!tbl_valid[set]) begin
                oc = OUT_EMPTY;
            end else begin
                old_page = {tbl_tag[set], set};
                slot = -1;
                for (int i = 0; i < VSLOTS; i++)
                    if (slot < 0 && vb_valid[i] && vb_page[i] == page) slot = i;
                if (slot >= 0) begin
                    oc = OUT_SWAP;
                    do_fill = 0;
                end else if (vb_used < VSLOTS) begin
                    slot = vb_used;
                    vb_used++;
                    oc = OUT_FREE;
                end else begin
                    best = 0;
                    for (int i = 1; i < VSLOTS; i++)
                        if (vb_tick[i] < vb_tick[best]) best = i;
                    slot = best;
                    oc = OUT_OLDEST;
                    gone = vb_page[best];
                    d = directory_lookup(gone);
                    if (d < 0 && dir_count < DSLOTS) begin
                        d = dir_count;
                        dir_page[dir_count] = gone;
                        dir_count++;
                    end
                    if (d >= 0) begin
                        ew = 1; epage = gone; eslot = d[11:0];
                    end else begin
                        full = 1;
                    end
                end
                vb_valid[slot] = 1;
                vb_page[slot] = old_page;
                vb_tick[slot] = tick;
                vslot = slot[2:0];
            end
            tbl_valid[set] = 1;
            tbl_tag[set] = tag;
            if (do_fill) begin
                f = directory_lookup(page);
                if (f >= 0) begin
                    fb = 1; fslot = f[11:0];
                end
            end
        end
        return pack_result(oc, set, vslot, ew, epage, eslot, fb, fslot, full);
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count,
                 field, got, want);
        fail_count++;
    endtask

    // one word on s_axis; gaps are drawn per word from idle_pct
    task automatic send_access(logic [50:0] page, logic [47:0] tick, bit fixed,
                               logic [95:0] want);
        logic [95:0] predicted;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, tick, page};
        do @(posedge aclk); while (!s_axis_tready);
        predicted = place_page(page, tick);
        pending_results = {pending_results, (fixed ? want : predicted)};
        words_sent++;
    endtask

    function automatic access_row_t row(logic [50:0] page, logic [47:0] tick,
                                       bit fixed = 0, logic [95:0] want = '0);
        access_row_t r;
        r.page = page; r.tick = tick; r.fixed = fixed; r.want = want;
        return r;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker, field by field against the oldest expectation
    always @(posedge aclk) begin
        logic [95:0] w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
            end else begin
                w = pending_results.pop_front();
                if (w[2:0] <= 3'd4) outcome_seen[w[2:0]]++;
                if (m_axis_tdata[2:0] != w[2:0])
                    report_mismatch("outcome", 64'(m_axis_tdata[2:0]), 64'(w[2:0]));
                if (m_axis_tdata[12:3] != w[12:3])
                    report_mismatch("set_index", 64'(m_axis_tdata[12:3]), 64'(w[12:3]));
                if (m_axis_tdata[15:13] != w[15:13])
                    report_mismatch("victim_slot", 64'(m_axis_tdata[15:13]),
                                    64'(w[15:13]));
                if (m_axis_tdata[16] != w[16])
                    report_mismatch("evict_write", 64'(m_axis_tdata[16]), 64'(w[16]));
                if (m_axis_tdata[67:17] != w[67:17])
                    report_mismatch("evicted_page", 64'(m_axis_tdata[67:17]),
                                    64'(w[67:17]));
                if (m_axis_tdata[79:68] != w[79:68])
                    report_mismatch("evict_slot", 64'(m_axis_tdata[79:68]),
                                    64'(w[79:68]));
                if (m_axis_tdata[80] != w[80])
                    report_mismatch("fill_from_backing", 64'(m_axis_tdata[80]),
                                    64'(w[80]));
                if (m_axis_tdata[92:81] != w[92:81])
                    report_mismatch("fill_slot", 64'(m_axis_tdata[92:81]),
                                    64'(w[92:81]));
                if (m_axis_tdata[93] != w[93])
                    report_mismatch("backing_full", 64'(m_axis_tdata[93]), 64'(w[93]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[page_table_victim_placement] ERROR");
            $finish;
        end
    end

    initial begin
        logic [50:0] pg;
        logic [47:0] tk;
        logic [47:0] tick_run;
        logic [9:0]  hot_set [4];
        int          sel;
        for (int i = 0; i < SETS; i++) begin
            tbl_valid[i] = 0; tbl_tag[i] = '0;
        end
        for (int i = 0; i < VSLOTS; i++) begin
            vb_valid[i] = 0; vb_page[i] = '0; vb_tick[i] = '0;
        end
        vb_used = 0;
        dir_count = 0;

        // directed table; typed expectations only where obvious
        directed = {directed, row(51'd0, 48'd0, 1,
            pack_result(OUT_EMPTY, 10'd0, 3'd0, 0, '0, '0, 0, '0, 0))};
        directed = {directed, row(51'd0, 48'd5, 1,
            pack_result(OUT_HIT, 10'd0, 3'd0, 0, '0, '0, 0, '0, 0))};
        directed = {directed, row(PAGE_MAX, TICK_MAX, 1,
            pack_result(OUT_EMPTY, 10'd1023, 3'd0, 0, '0, '0, 0, '0, 0))};
        directed = {directed, row(PAGE_MAX, 48'd0, 1,
            pack_result(OUT_HIT, 10'd1023, 3'd0, 0, '0, '0, 0, '0, 0))};
        // set 0 miss: resident page 0 takes free slot 0
        directed = {directed, row(51'd1024, 48'd0, 1,
            pack_result(OUT_FREE, 10'd0, 3'd0, 0, '0, '0, 0, '0, 0))};
        // page 0 sits in slot 0: swap back
        directed = {directed, row(51'd0, 48'd0, 1,
            pack_result(OUT_SWAP, 10'd0, 3'd0, 0, '0, '0, 0, '0, 0))};
        // fill the victim buffer with equal ticks, then evict: tie to lowest slot
        for (int k = 2; k <= 12; k++) directed = {directed, row(51'(k * 1024), 48'd0)};
        directed = {directed, row(51'd2048, 48'd7)};
        directed = {directed, row(51'd1024, TICK_MAX)};
        directed = {directed, row(51'h2AAAAAAAAAAAA, 48'h555555555555)};
        directed = {directed, row(51'h5555555555555, 48'hAAAAAAAAAAAA)};
        directed = {directed, row(51'd1023, TICK_MAX)};
        directed = {directed, row(51'd0, 48'd3)};

        // small page pool over four sets keeps the directory short
        for (int i = 0; i < 4; i++) hot_set[i] = 10'($urandom);
        for (int i = 0; i < POOL_SIZE; i++)
            page_pool[i] = {41'({$urandom, $urandom}) & (i < 48 ? 41'hF : '1),
                            hot_set[i % 4]};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_access(directed[i].page, directed[i].tick, directed[i].fixed,
                        directed[i].want);

        tick_run = 48'd100;
        for (int n = 0; n < RAND_WORDS; n++) begin
            // four traffic phases across the random part
            case (n * 4 / RAND_WORDS)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            if (n == 200) long_hold_req <= 1'b1;
            if (n == 900) begin
                // drain completely before carrying on
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            sel = $urandom_range(99);
            if (sel < 5) pg = 51'({$urandom, $urandom});
            else pg = page_pool[$urandom_range(POOL_SIZE - 1)];
            sel = $urandom_range(99);
            tick_run += 48'($urandom_range(3));
            if (sel < 10)      tk = 48'({$urandom, $urandom});
            else if (sel < 15) tk = vb_tick[$urandom_range(VSLOTS - 1)];
            else               tk = tick_run;
            send_access(pg, tk, 0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("%0d accesses: hit %0d, empty %0d, swap %0d, free %0d, evict %0d",
                 words_sent, outcome_seen[0], outcome_seen[1], outcome_seen[2],
                 outcome_seen[3], outcome_seen[4]);
        $display("directory entries used %0d, under idle and stall phases", dir_count);
        if (fail_count == 0) begin
            $display("[page_table_victim_placement] OK");
        end else begin
            $display("[page_table_victim_placement] ERROR");
        end
        $finish;
    end

endmodule
